@@ hw/rtl/safk_pkg.sv @@
package safk_pkg;

	localparam int ANGLE_W = 16;
	localparam int OUT_W = 24;
	localparam int PT_W = 21;
	localparam int Q30_W = 32;
	localparam int ATAN_ENTRIES = 24;
	localparam int JOINTS = 6;
	localparam int ANGLE_FRAC_BITS = 12;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
	localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_j0;
		logic signed [ANGLE_W-1:0] angle_j1;
		logic signed [ANGLE_W-1:0] angle_j2;
		logic signed [ANGLE_W-1:0] angle_j3;
		logic signed [ANGLE_W-1:0] angle_j4;
		logic signed [ANGLE_W-1:0] angle_j5;
	} angles_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] tip_x;
		logic signed [OUT_W-1:0] tip_y;
		logic signed [OUT_W-1:0] tip_z;
	} tip_t;

	function automatic logic signed [35:0] atan_q30(input int i);
		case (i)
			0: atan_q30 = 36'sd843314856;
			1: atan_q30 = 36'sd497837829;
			2: atan_q30 = 36'sd263043836;
			3: atan_q30 = 36'sd133525158;
			4: atan_q30 = 36'sd67021686;
			5: atan_q30 = 36'sd33543515;
			6: atan_q30 = 36'sd16775850;
			7: atan_q30 = 36'sd8388437;
			8: atan_q30 = 36'sd4194282;
			9: atan_q30 = 36'sd2097149;
			10: atan_q30 = 36'sd1048575;
			11: atan_q30 = 36'sd524287;
			12: atan_q30 = 36'sd262143;
			13: atan_q30 = 36'sd131071;
			14: atan_q30 = 36'sd65535;
			15: atan_q30 = 36'sd32767;
			16: atan_q30 = 36'sd16383;
			17: atan_q30 = 36'sd8191;
			18: atan_q30 = 36'sd4095;
			19: atan_q30 = 36'sd2047;
			20: atan_q30 = 36'sd1023;
			21: atan_q30 = 36'sd511;
			22: atan_q30 = 36'sd255;
			23: atan_q30 = 36'sd127;
			default: atan_q30 = 36'sd0;
		endcase
	endfunction

endpackage

@@ hw/rtl/safk_cordic.sv @@
// pipelined sin/cos: reduce stage, one stage per step, clamp stage
module safk_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic signed [safk_pkg::ANGLE_W-1:0] angle,
	input  logic negate,
	output logic signed [31:0] sin_out,
	output logic signed [31:0] cos_out
);
	localparam int ST = (CORDIC_STEPS < safk_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
		: safk_pkg::ATAN_ENTRIES;
	localparam int AW = 36 + 1;
	localparam logic signed [AW-1:0] TWO_PI = AW'(safk_pkg::PI_Q30) * 2;

	logic signed [AW-1:0] r_s [0:ST];
	logic signed [35:0] x_s [0:ST];
	logic signed [35:0] y_s [0:ST];
	logic neg_s [0:ST];

	logic signed [AW-1:0] a0, r0;
	logic fold;

	always_comb begin
		a0 = AW'(angle) <<< (30 - safk_pkg::ANGLE_FRAC_BITS);
		if (negate)
			a0 = -a0;
		// |a0| <= 2^33 stays under two turns, one step gives the truncated remainder
		r0 = a0;
		if (r0 >= TWO_PI)
			r0 = r0 - TWO_PI;
		else if (r0 <= -TWO_PI)
			r0 = r0 + TWO_PI;
		if (r0 > AW'(safk_pkg::PI_Q30))
			r0 = r0 - TWO_PI;
		if (r0 < -AW'(safk_pkg::PI_Q30))
			r0 = r0 + TWO_PI;
		fold = 1'b0;
		if (r0 > AW'(safk_pkg::HALF_PI_Q30)) begin
			r0 = r0 - AW'(safk_pkg::PI_Q30);
			fold = 1'b1;
		end else if (r0 < -AW'(safk_pkg::HALF_PI_Q30)) begin
			r0 = r0 + AW'(safk_pkg::PI_Q30);
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= r0;
			x_s[0] <= safk_pkg::GAIN_Q30;
			y_s[0] <= '0;
			neg_s[0] <= fold;
		end
	end

	for (genvar i = 0; i < ST; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				if (r_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					r_s[i+1] <= r_s[i] - AW'(safk_pkg::atan_q30(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					r_s[i+1] <= r_s[i] + AW'(safk_pkg::atan_q30(i));
				end
			end
		end
	end

	logic signed [35:0] xf, yf;
	always_comb begin
		xf = neg_s[ST] ? -x_s[ST] : x_s[ST];
		yf = neg_s[ST] ? -y_s[ST] : y_s[ST];
		if (xf > safk_pkg::ONE_Q30) xf = safk_pkg::ONE_Q30;
		if (xf < -safk_pkg::ONE_Q30) xf = -safk_pkg::ONE_Q30;
		if (yf > safk_pkg::ONE_Q30) yf = safk_pkg::ONE_Q30;
		if (yf < -safk_pkg::ONE_Q30) yf = -safk_pkg::ONE_Q30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= 32'(xf);
			sin_out <= 32'(yf);
		end
	end

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

@@ hw/rtl/serial_arm_forward_kinematics_unit.sv @@
// path from the accepting edge to out_valid with no stall: min(CORDIC_STEPS, 24) + 2
// sin/cos registers, one skew register, the joint 0 register, 5 joint stages of a
// product register and a rounded sum register each, and the output register
// throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits on out_ready
// reset clears all valid bits and the six link registers to zero
module serial_arm_forward_kinematics_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  safk_pkg::angles_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output safk_pkg::tip_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam int ST = (CORDIC_STEPS < safk_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
		: safk_pkg::ATAN_ENTRIES;
	localparam int CL = ST + 2;
	localparam int DEPTH = CL + 13;

	logic [62:0] link_q [0:5];
	logic en;
	logic [DEPTH-1:0] vld_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) link_q[i] <= '0;
		end else if (psel && penable && pwrite && paddr[5:3] < 3'd6) begin
			link_q[paddr[5:3]] <= pwdata[62:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[5:3] < 3'd6)
			prdata = {1'b0, link_q[paddr[5:3]]};
	end

	// single stall point at the output register
	assign en = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	logic signed [safk_pkg::ANGLE_W-1:0] ang [0:4];
	assign ang[0] = in_data.angle_j0;
	assign ang[1] = in_data.angle_j1;
	assign ang[2] = in_data.angle_j2;
	assign ang[3] = in_data.angle_j3;
	assign ang[4] = in_data.angle_j4;
	localparam logic [1:0] AX [0:4] = '{safk_pkg::AXIS_Z, safk_pkg::AXIS_Y,
		safk_pkg::AXIS_Y, safk_pkg::AXIS_X, safk_pkg::AXIS_Y};

	logic signed [31:0] sn [0:4];
	logic signed [31:0] cs [0:4];
	for (genvar j = 0; j < 5; j++) begin : g_trig
		safk_cordic #(.CORDIC_STEPS(CORDIC_STEPS))
			u_cordic (.clk, .arst_n, .en, .angle(ang[j]),
			.negate(AX[j] != safk_pkg::AXIS_Y), .sin_out(sn[j]), .cos_out(cs[j]));
	end

	// delay lines: sin/cos of joint j needed at joint stage j
	logic signed [31:0] sd_q [0:4][0:9];
	logic signed [31:0] cd_q [0:4][0:9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 5; j++) begin
				sd_q[j][0] <= sn[j];
				cd_q[j][0] <= cs[j];
				for (int d = 1; d < 10; d++) begin
					sd_q[j][d] <= sd_q[j][d-1];
					cd_q[j][d] <= cd_q[j][d-1];
				end
			end
		end
	end

	// joint pipeline: rotation and position
	logic signed [31:0] rot_s [0:5][0:2][0:2];
	logic signed [39:0] pos_s [0:5][0:2];
	logic signed [63:0] prod_s [0:4][0:2][0:2];
	logic signed [63:0] mv_s [0:4][0:2];
	logic signed [39:0] pposm_s [0:4][0:2];

	function automatic logic signed [21:0] coord(input logic [62:0] v, input int k);
		coord = 22'($signed(v[21*k +: 21]));
	endfunction

	function automatic logic signed [31:0] elem(input logic [1:0] ax, input int q,
			input int k, input logic signed [31:0] s, input logic signed [31:0] c);
		int a, b;
		a = (ax == safk_pkg::AXIS_Z) ? int'(safk_pkg::AXIS_X) : int'(ax) + 1;
		b = (ax == safk_pkg::AXIS_X) ? int'(safk_pkg::AXIS_Z) : int'(ax) - 1;
		elem = '0;
		if (q == ax && k == ax) elem = 32'sd1073741824;
		else if (q == a && k == a) elem = c;
		else if (q == b && k == b) elem = c;
		else if (q == a && k == b) elem = -s;
		else if (q == b && k == a) elem = s;
	endfunction

	function automatic logic signed [39:0] rnd(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = (v + 64'sd536870912) >>> 30;
		rnd = 40'(t);
	endfunction

	// stage 0 of joints: rotation = E0, position = point0
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pos_s[0][r] <= 40'(coord(link_q[0], r));
				for (int k = 0; k < 3; k++)
					rot_s[0][r][k] <= elem(safk_pkg::AXIS_Z, r, k, sd_q[0][0], cd_q[0][0]);
			end
		end
	end

	// joint i: products are summed into one register, then rounded (and added to the position) into the next
	for (genvar i = 1; i < 6; i++) begin : g_joint
		localparam logic [1:0] AXI = (i == 1 || i == 2 || i == 4) ? safk_pkg::AXIS_Y
			: (i == 3 || i == 5) ? safk_pkg::AXIS_X : safk_pkg::AXIS_Z;
		if (i < 5) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					for (int r = 0; r < 3; r++)
						for (int k = 0; k < 3; k++) begin
							prod_s[i-1][r][k] <=
								64'(rot_s[i-1][r][0]) * elem(AXI, 0, k, sd_q[i][2*i-1], cd_q[i][2*i-1])
								+ 64'(rot_s[i-1][r][1]) * elem(AXI, 1, k, sd_q[i][2*i-1], cd_q[i][2*i-1])
								+ 64'(rot_s[i-1][r][2]) * elem(AXI, 2, k, sd_q[i][2*i-1], cd_q[i][2*i-1]);
						end
					for (int r = 0; r < 3; r++)
						for (int k = 0; k < 3; k++)
							rot_s[i][r][k] <= 32'(rnd(prod_s[i-1][r][k]));
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int r = 0; r < 3; r++) begin
					mv_s[i-1][r] <=
						64'(rot_s[i-1][r][0]) * 64'(coord(link_q[i], 0) - coord(link_q[i-1], 0))
						+ 64'(rot_s[i-1][r][1]) * 64'(coord(link_q[i], 1) - coord(link_q[i-1], 1))
						+ 64'(rot_s[i-1][r][2]) * 64'(coord(link_q[i], 2) - coord(link_q[i-1], 2));
					pposm_s[i-1][r] <= pos_s[i-1][r];
					pos_s[i][r] <= pposm_s[i-1][r] + rnd(mv_s[i-1][r]);
				end
			end
		end
	end

	// stage timing: rot_s[i] (i < 5) and pos_s[i] come from [i-1] through the prod_s, mv_s and pposm_s registers
	function automatic logic signed [23:0] sat(input logic signed [39:0] v);
		if (v > 40'sd8388607) sat = 24'sd8388607;
		else if (v < -40'sd8388608) sat = -24'sd8388608;
		else sat = 24'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.tip_x <= sat(pos_s[5][0]);
			out_data.tip_y <= sat(pos_s[5][1]);
			out_data.tip_z <= sat(pos_s[5][2]);
		end
	end

	logic unused_j5;
	assign unused_j5 = ^in_data.angle_j5 ^ ^prdata[63:63];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result lost under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline stalled with empty output");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item not tracked");
endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = safk_pkg::ANGLE_FRAC_BITS;
	localparam int STEPS = 16;
	localparam int LAT = STEPS + 14;

	class tip_scoreboard;
		safk_pkg::tip_t expected_tips[$];
		logic [62:0] link_pt[safk_pkg::JOINTS];
		int errors = 0;
		longint atan_tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		logic [1:0] axis_of[safk_pkg::JOINTS] = '{safk_pkg::AXIS_Z, safk_pkg::AXIS_Y,
			safk_pkg::AXIS_Y, safk_pkg::AXIS_X, safk_pkg::AXIS_Y, safk_pkg::AXIS_X};

		function void set_link(int idx, logic [63:0] v);
			if (idx < safk_pkg::JOINTS) link_pt[idx] = v[62:0];
		endfunction

		function void sin_cos(longint a, output longint s, output longint c);
			longint pi, r, x, y, nx;
			bit neg;
			pi = 64'sd3373259426;
			r = a % (2 * pi);
			x = 652032874;
			y = 0;
			neg = 0;
			if (r > pi) r -= 2 * pi;
			if (r < -pi) r += 2 * pi;
			if (r > pi / 2) begin
				r -= pi;
				neg = 1;
			end else if (r < -(pi / 2)) begin
				r += pi;
				neg = 1;
			end
			for (int i = 0; i < STEPS && i < 24; i++) begin
				if (r >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					r -= atan_tab[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					r += atan_tab[i];
				end
				x = nx;
			end
			if (neg) begin
				x = -x;
				y = -y;
			end
			c = x > 1073741824 ? 1073741824 : (x < -1073741824 ? -1073741824 : x);
			s = y > 1073741824 ? 1073741824 : (y < -1073741824 ? -1073741824 : y);
		endfunction

		function longint rnd30(longint v);
			return (v + 64'sd536870912) >>> 30;
		endfunction

		function void note_pose(safk_pkg::angles_t p);
			longint ang[safk_pkg::JOINTS], rot[3][3], e[3][3], nr[3][3];
			longint pos[3], prev[3], cur[3], off[3], s, c, acc, one, lim;
			int a1, a2, ax;
			safk_pkg::tip_t t;
			one = 1073741824;
			ang = '{p.angle_j0, p.angle_j1, p.angle_j2, p.angle_j3, p.angle_j4, p.angle_j5};
			for (int i = 0; i < safk_pkg::JOINTS; i++) begin
				ax = axis_of[i];
				if (axis_of[i] != safk_pkg::AXIS_Y) ang[i] = -ang[i];
				sin_cos(ang[i] * (64'sd1 << (30 - FRAC)), s, c);
				a1 = (ax + 1) % 3;
				a2 = (ax + 2) % 3;
				foreach (e[j, k]) e[j][k] = 0;
				e[ax][ax] = one;
				e[a1][a1] = c;
				e[a2][a2] = c;
				e[a1][a2] = -s;
				e[a2][a1] = s;
				cur[0] = longint'($signed(link_pt[i][20:0]));
				cur[1] = longint'($signed(link_pt[i][41:21]));
				cur[2] = longint'($signed(link_pt[i][62:42]));
				if (i == 0) begin
					pos = cur;
					rot = e;
				end else begin
					for (int j = 0; j < 3; j++) off[j] = cur[j] - prev[j];
					for (int j = 0; j < 3; j++) begin
						acc = 0;
						for (int k = 0; k < 3; k++) acc += rot[j][k] * off[k];
						pos[j] += rnd30(acc);
					end
					foreach (nr[j, k]) begin
						acc = 0;
						for (int q = 0; q < 3; q++) acc += rot[j][q] * e[q][k];
						nr[j][k] = rnd30(acc);
					end
					rot = nr;
				end
				prev = cur;
			end
			lim = 8388607;
			for (int j = 0; j < 3; j++)
				pos[j] = pos[j] > lim ? lim : (pos[j] < -lim - 1 ? -lim - 1 : pos[j]);
			t.tip_x = pos[0][safk_pkg::OUT_W-1:0];
			t.tip_y = pos[1][safk_pkg::OUT_W-1:0];
			t.tip_z = pos[2][safk_pkg::OUT_W-1:0];
			expected_tips = {expected_tips, t};
		endfunction

		function void check_tip(safk_pkg::tip_t got);
			safk_pkg::tip_t want;
			if (expected_tips.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected tip %h", got);
				return;
			end
			want = expected_tips.pop_front();
			if (got.tip_x !== want.tip_x || got.tip_y !== want.tip_y
					|| got.tip_z !== want.tip_z) begin
				errors++;
				if (errors <= 10)
					$display("tip mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
						want.tip_x, want.tip_y, want.tip_z, got.tip_x, got.tip_y, got.tip_z);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	safk_pkg::angles_t in_data;
	safk_pkg::tip_t out_data;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	bit quiet = 0;
	tip_scoreboard tips = new;

	serial_arm_forward_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tips.check_tip(out_data);
		out_ready <= quiet || $urandom_range(99) >= 23;
	end

	task send_pose(safk_pkg::angles_t p);
		while (!quiet && $urandom_range(99) < 23) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		tips.note_pose(p);
	endtask

	task drain();
		int n;
		in_valid <= 0;
		n = 0;
		while (tips.expected_tips.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (LAT + 10) @(posedge clk);
	endtask

	// psel stays high between back to back writes, load_links drops it at the end
	task reg_write(int idx, logic [63:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 6'(idx * 8);
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		tips.set_link(idx, v);
	endtask

	function automatic logic [62:0] pack_pt(logic [20:0] x, logic [20:0] y, logic [20:0] z);
		return {z, y, x};
	endfunction

	function automatic safk_pkg::angles_t rand_pose();
		safk_pkg::angles_t p;
		if ($urandom_range(3) == 0) p = {$urandom, $urandom, $urandom};
		else begin
			p.angle_j0 = 16'($urandom_range(25736) - 12868);
			p.angle_j1 = 16'($urandom_range(25736) - 12868);
			p.angle_j2 = 16'($urandom_range(25736) - 12868);
			p.angle_j3 = 16'($urandom_range(25736) - 12868);
			p.angle_j4 = 16'($urandom_range(25736) - 12868);
			p.angle_j5 = 16'($urandom);
		end
		return p;
	endfunction

	// link setting per phase: random, alternating extremes, all max, all min, zero
	task load_links(int mode);
		logic [63:0] v;
		for (int i = 0; i < safk_pkg::JOINTS; i++) begin
			case (mode)
				1: v = (i % 2) ? {1'b1, pack_pt(21'h100000, 21'h100000, 21'h100000)}
					: {1'b0, pack_pt(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF)};
				2: v = {1'b0, pack_pt(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF)};
				3: v = {1'b1, pack_pt(21'h100000, 21'h100000, 21'h100000)};
				4: v = 64'd0;
				default: v = {$urandom, $urandom};
			endcase
			reg_write(i, v);
		end
		// writes outside the register map must be ignored
		reg_write(6, {$urandom, $urandom});
		reg_write(7, {$urandom, $urandom});
		psel <= 0;
		penable <= 0;
	endtask

	initial begin
		safk_pkg::angles_t p;
		logic signed [15:0] dir_vals[8];
		dir_vals = '{0, 1, -1, 32767, -32768, 6434, -6434, 12868};
		arst_n <= 0;
		in_valid <= 0;
		in_data <= '0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		out_ready <= 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		load_links(0);
		foreach (dir_vals[v])
			send_pose({6{dir_vals[v]}});
		for (int j = 0; j < safk_pkg::JOINTS; j++) begin
			p = '0;
			p[16*(5-j) +: 16] = (j % 2) ? 16'sh8000 : 16'sh7FFF;
			send_pose(p);
		end
		// last joint alone must not move the tip
		send_pose({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF});
		send_pose({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000});
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			load_links(ph == 5 ? 0 : ph);
			for (int n = 0; n < 150; n++) begin
				quiet = (ph == 2 && n >= 20 && n < 120);
				send_pose(ph == 1 && n < 20 ? {6{dir_vals[n % 8]}} : rand_pose());
			end
			quiet = 0;
		end
		drain();
		tips.errors += tips.expected_tips.size();
		if (tips.errors == 0)
			$display("serial_arm_forward_kinematics_unit test passed");
		else
			$display("serial_arm_forward_kinematics_unit test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("serial_arm_forward_kinematics_unit test failed");
		$finish;
	end
endmodule
